// ===== hw/rtl/epws_pkg.sv =====
// Shared types and constants of the EEPROM page-write sequencer.
// Used by the front end, the descriptor queue, the command back end and the top level.
package epws_pkg;

	// Bus command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_SEND  = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_WAIT  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_WIDE_ADDRESS   = 1'b0;
	localparam logic CFG_PAGE_SIZE_LOG2 = 1'b1;

	// Reset values of the configuration registers
	localparam logic       WIDE_ADDRESS_RST   = 1'b1;
	localparam logic [3:0] PAGE_SIZE_LOG2_RST = 4'd4;

	// Device address byte base
	localparam logic [7:0] DEVICE_BASE = 8'hA0;

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;

	// Number of command slots one byte can expand to
	localparam int NSLOTS = 13;

	// One classified byte, ready for expansion into bus commands
	typedef struct packed {
		logic        first;      // open a write at open_addr before the data
		logic [15:0] open_addr;  // address of the data byte
		logic [7:0]  data;       // data byte
		logic        boundary;   // close and reopen at next_addr after the data
		logic [15:0] next_addr;  // address after the data byte
		logic        last;       // close the write at the end
		logic        wide;       // two address bytes
	} desc_t;

endpackage

// ===== hw/rtl/epws_front.sv =====
// Front end of the EEPROM page-write sequencer: configuration registers, burst state,
// classification of each accepted byte into a descriptor. Depends on epws_pkg.
module epws_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [3:0]           cfg_data,
	input  logic                 in_accept,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          start_address,
	input  logic                 first,
	input  logic                 last,
	output logic                 push,
	output epws_pkg::desc_t      push_desc
);

	logic        wide_q;
	logic [3:0]  psz_q;
	logic [15:0] cur_addr_q;
	logic        open_q;

	logic [15:0] base_addr;
	logic [15:0] next_addr;
	logic [15:0] page_mask;
	logic        boundary;

	// Classify the incoming byte
	always_comb begin
		base_addr = first ? start_address : cur_addr_q;
		next_addr = base_addr + 16'd1;
		page_mask = 16'((17'd1 << psz_q) - 17'd1);
		boundary  = (next_addr & page_mask) == 16'd0;
		push      = in_accept && (first || open_q);

		push_desc.first     = first;
		push_desc.open_addr = base_addr;
		push_desc.data      = data_byte;
		push_desc.boundary  = boundary;
		push_desc.next_addr = next_addr;
		push_desc.last      = last;
		push_desc.wide      = wide_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= epws_pkg::WIDE_ADDRESS_RST;
			psz_q  <= epws_pkg::PAGE_SIZE_LOG2_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				epws_pkg::CFG_WIDE_ADDRESS:   wide_q <= cfg_data[0];
				epws_pkg::CFG_PAGE_SIZE_LOG2: psz_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the address and track the open burst; drop bytes outside a burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= 16'd0;
			open_q     <= 1'b0;
		end else if (push) begin
			cur_addr_q <= next_addr;
			open_q     <= !last;
		end
	end

endmodule

// ===== hw/rtl/epws_queue.sv =====
// Short descriptor queue between front and back of the page-write sequencer.
// Register array with read and write pointers. Depends on epws_pkg.
module epws_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  epws_pkg::desc_t      wr_data,
	output logic                 full,
	output logic                 rd_valid,
	output epws_pkg::desc_t      rd_data,
	input  logic                 rd_en
);

	localparam int PW = (epws_pkg::QDEPTH > 1) ? $clog2(epws_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(epws_pkg::QDEPTH + 1);

	epws_pkg::desc_t      mem_q [epws_pkg::QDEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;

	assign full     = count_q == CW'(epws_pkg::QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(epws_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(epws_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// A write never meets a full queue, a read never an empty one
	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !full)
		else $error("queue write while full");
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> rd_valid)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(epws_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule

// ===== hw/rtl/epws_back.sv =====
// Back end of the page-write sequencer: expands each descriptor into bus commands,
// one per cycle unless out_ready stalls, via a registered output stage. Depends on epws_pkg.
module epws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  epws_pkg::desc_t      q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           command,
	output logic [7:0]           bus_byte,
	output logic                 final_res
);

	localparam int SW = $clog2(epws_pkg::NSLOTS);

	// Command slots in emission order
	localparam logic [SW-1:0] SLOT_OPEN_START = SW'(0);
	localparam logic [SW-1:0] SLOT_OPEN_DEV   = SW'(1);
	localparam logic [SW-1:0] SLOT_OPEN_HI    = SW'(2);
	localparam logic [SW-1:0] SLOT_OPEN_LO    = SW'(3);
	localparam logic [SW-1:0] SLOT_DATA       = SW'(4);
	localparam logic [SW-1:0] SLOT_PG_STOP    = SW'(5);
	localparam logic [SW-1:0] SLOT_PG_WAIT    = SW'(6);
	localparam logic [SW-1:0] SLOT_PG_START   = SW'(7);
	localparam logic [SW-1:0] SLOT_PG_DEV     = SW'(8);
	localparam logic [SW-1:0] SLOT_PG_HI      = SW'(9);
	localparam logic [SW-1:0] SLOT_PG_LO      = SW'(10);
	localparam logic [SW-1:0] SLOT_END_STOP   = SW'(11);
	localparam logic [SW-1:0] SLOT_END_WAIT   = SW'(12);

	epws_pkg::desc_t              cur_q;
	logic [epws_pkg::NSLOTS-1:0]  rem_q;
	logic                         active_q;
	logic                         out_valid_q;
	logic [1:0]                   cmd_q;
	logic [7:0]                   byte_q;
	logic                         fin_q;

	logic [SW-1:0]                slot;
	logic [epws_pkg::NSLOTS-1:0]  rem_next;
	logic                         fin;
	logic                         load_out;
	logic [epws_pkg::NSLOTS-1:0]  new_mask;
	logic [15:0]                  sel_addr;
	logic [7:0]                   dev_byte;
	logic [1:0]                   cmd_d;
	logic [7:0]                   byte_d;

	// Slots that a descriptor enables
	always_comb begin
		new_mask = {q_data.last, q_data.last,
			q_data.boundary, q_data.boundary & q_data.wide, q_data.boundary,
			q_data.boundary, q_data.boundary, q_data.boundary,
			1'b1,
			q_data.first, q_data.first & q_data.wide, q_data.first, q_data.first};
	end

	// Pick the lowest pending slot
	always_comb begin
		slot = '0;
		for (int i = epws_pkg::NSLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				slot = SW'(i);
			end
		end
		rem_next = rem_q & ~(epws_pkg::NSLOTS'(1) << slot);
		fin      = rem_next == '0;
		load_out = active_q && (!out_valid_q || out_ready);
		q_pop    = q_valid && (!active_q || (load_out && fin));
	end

	// Build the command of the chosen slot
	always_comb begin
		sel_addr = (slot < SLOT_PG_STOP) ? cur_q.open_addr : cur_q.next_addr;
		dev_byte = cur_q.wide ? epws_pkg::DEVICE_BASE
			: epws_pkg::DEVICE_BASE + {sel_addr[14:8], 1'b0};
		unique case (slot)
			SLOT_OPEN_START, SLOT_PG_START: begin
				cmd_d  = epws_pkg::CMD_START;
				byte_d = 8'd0;
			end
			SLOT_OPEN_DEV, SLOT_PG_DEV: begin
				cmd_d  = epws_pkg::CMD_SEND;
				byte_d = dev_byte;
			end
			SLOT_OPEN_HI, SLOT_PG_HI: begin
				cmd_d  = epws_pkg::CMD_SEND;
				byte_d = sel_addr[15:8];
			end
			SLOT_OPEN_LO, SLOT_PG_LO: begin
				cmd_d  = epws_pkg::CMD_SEND;
				byte_d = sel_addr[7:0];
			end
			SLOT_DATA: begin
				cmd_d  = epws_pkg::CMD_SEND;
				byte_d = cur_q.data;
			end
			SLOT_PG_STOP, SLOT_END_STOP: begin
				cmd_d  = epws_pkg::CMD_STOP;
				byte_d = 8'd0;
			end
			SLOT_PG_WAIT, SLOT_END_WAIT: begin
				cmd_d  = epws_pkg::CMD_WAIT;
				byte_d = 8'd0;
			end
			default: begin
				cmd_d  = epws_pkg::CMD_START;
				byte_d = 8'd0;
			end
		endcase
	end

	// Hold the current descriptor
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	// Track pending slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			active_q <= 1'b0;
		end else if (q_pop) begin
			rem_q    <= new_mask;
			active_q <= 1'b1;
		end else if (load_out) begin
			rem_q <= rem_next;
			if (fin) begin
				active_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cmd_q  <= cmd_d;
			byte_q <= byte_d;
			fin_q  <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = cmd_q;
	assign bus_byte  = byte_q;
	assign final_res = fin_q;

	// An active descriptor always has a pending slot
	assert property (@(posedge clk) disable iff (!arst_n) active_q |-> rem_q != '0)
		else $error("active descriptor with no pending command");
	// A loaded descriptor always has its data slot pending
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> rem_q[SLOT_DATA])
		else $error("descriptor loaded without data command");
	// Finishing with nothing queued leaves the back end idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && fin && !q_valid) |=> !active_q)
		else $error("back end stayed active after its last command");

endmodule

// ===== hw/rtl/eeprom_page_write_sequencer_top.sv =====
// Path: an accepted transfer is written into the descriptor queue, popped into the back end's
// descriptor register, and each of its commands is registered in the output stage behind m_tvalid.
// One bus command per cycle while m_tready keeps the output free; a byte causes 1 to 13 commands.
// Input transfers continue while the four-entry descriptor queue has room.
// Reset (arst_n low): burst closed, address zero, wide_address 1, page_size_log2 4, queue empty.
module eeprom_page_write_sequencer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // [7:0] data_byte, [23:8] start_address
	input  logic         s_tuser,   // [0] first
	input  logic         s_tlast,   // last byte of the burst
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,   // [1:0] command, [9:2] bus_byte, [15:10] zero
	output logic         m_tlast,   // final_res
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [3:0]   cfg_data
);

	logic                push;
	epws_pkg::desc_t     push_desc;
	logic                q_full;
	logic                q_valid;
	epws_pkg::desc_t     q_data;
	logic                q_pop;
	logic [1:0]          command;
	logic [7:0]          bus_byte;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;

	// Classify and track the burst
	epws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_accept     (s_tvalid && s_tready),
		.data_byte     (s_tdata[7:0]),
		.start_address (s_tdata[23:8]),
		.first         (s_tuser),
		.last          (s_tlast),
		.push          (push),
		.push_desc     (push_desc)
	);

	// Decouple front and back
	epws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (push_desc),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.rd_en    (q_pop)
	);

	// Expand into bus commands
	epws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.command   (command),
		.bus_byte  (bus_byte),
		.final_res (m_tlast)
	);

	assign m_tdata = {6'd0, bus_byte, command};

endmodule
